// ===== sv/alen_pkg.sv =====
// Shared constants and types for the array list engine.
// No dependencies; used by alen_cmp and array_list_engine_core.
`timescale 1ns / 1ps

package alen_pkg;

   localparam int CAPACITY = 1024;
   localparam int ADDR_W   = $clog2(CAPACITY);
   localparam int CNT_W    = $clog2(CAPACITY + 1);
   localparam int DATA_W   = 32;
   localparam int KIND_W   = 3;
   localparam int STAT_W   = 3;
   localparam int SLOT_W   = 10;

   // Request payload: value, new_value, slot, padded to whole bytes.
   localparam int REQ_RAW_W  = 2 * DATA_W + SLOT_W;
   localparam int REQ_DATA_W = ((REQ_RAW_W + 7) / 8) * 8;
   // Response payload: status, found_at, largest, length.
   localparam int RSP_RAW_W  = STAT_W + SLOT_W + DATA_W + CNT_W;
   localparam int RSP_DATA_W = ((RSP_RAW_W + 7) / 8) * 8;

   localparam logic [KIND_W-1:0] KIND_APPEND  = 3'd0;
   localparam logic [KIND_W-1:0] KIND_REPLACE = 3'd1;
   localparam logic [KIND_W-1:0] KIND_DELETE  = 3'd2;
   localparam logic [KIND_W-1:0] KIND_FIND    = 3'd3;
   localparam logic [KIND_W-1:0] KIND_WRITE   = 3'd4;
   localparam logic [KIND_W-1:0] KIND_MAX     = 3'd5;

   localparam logic [STAT_W-1:0] STAT_OK        = 3'd0;
   localparam logic [STAT_W-1:0] STAT_NOT_FOUND = 3'd1;
   localparam logic [STAT_W-1:0] STAT_FULL      = 3'd2;
   localparam logic [STAT_W-1:0] STAT_RANGE     = 3'd3;
   localparam logic [STAT_W-1:0] STAT_EMPTY     = 3'd4;

   typedef struct packed {
      logic eq;
      logic gt;
   } cmp_res_type;

endpackage

// ===== sv/alen_cmp.sv =====
// Shared word comparator: equality and two's complement greater-than.
// Depends on alen_pkg.
`timescale 1ns / 1ps

module alen_cmp (
   input  logic signed [alen_pkg::DATA_W-1:0] a,
   input  logic signed [alen_pkg::DATA_W-1:0] b,
   output alen_pkg::cmp_res_type               res
);

   always_comb begin
      res.eq = (a == b);
      res.gt = (a > b);
   end

endmodule

// ===== sv/array_list_engine_core.sv =====
// Top level of the array list engine: list memory, sequencer and result register.
// Depends on alen_pkg and alen_cmp.
`timescale 1ns / 1ps
//
// The block holds a packed list of up to 1024 signed words and its count.
// Each request on the req_ channel carries one operation in req_tuser
// (append, replace all, delete first, find last, write at slot, maximum)
// and yields exactly one response on the rsp_ channel with a status, the
// found position, the largest word and the list length after the operation.
// Append, write at slot and unknown kinds go from idle straight to finish.
// Replace, find and maximum walk the list one word per cycle through the
// single read port of the list memory and one shared comparator. Delete
// walks to the first match, then shifts the tail down one word per cycle.
// req_tready is high only while the sequencer is idle. A new request may be
// accepted while the previous response still waits in the output register;
// the sequencer then holds its finished result until that one is taken.
// Reset empties the list and drops any pending response; the memory
// contents are not cleared, since only words below the count are read.
//

module array_list_engine_core (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   // From bit 0: value[31:0], new_value[63:32], slot[73:64], zero padding.
   input  logic [alen_pkg::REQ_DATA_W-1:0]      req_tdata,
   // kind[2:0]
   input  logic [alen_pkg::KIND_W-1:0]          req_tuser,
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   // From bit 0: status[2:0], found_at[12:3], largest[44:13], length[55:45].
   output logic [alen_pkg::RSP_DATA_W-1:0]      rsp_tdata
);

   typedef enum logic [3:0] {
      ST_IDLE   = 4'b0001,
      ST_WALK   = 4'b0010,
      ST_SHIFT  = 4'b0100,
      ST_FINISH = 4'b1000
   } state_type;

   localparam int ADDR_W = alen_pkg::ADDR_W;
   localparam int CNT_W  = alen_pkg::CNT_W;
   localparam int DATA_W = alen_pkg::DATA_W;

   state_type                    state_ff, state_in;
   logic [alen_pkg::KIND_W-1:0]  kind_ff, kind_in;
   logic [DATA_W-1:0]            value_ff, value_in;
   logic [DATA_W-1:0]            nval_ff, nval_in;
   logic [CNT_W-1:0]             count_ff, count_in;
   logic [CNT_W-1:0]             rd_ptr_ff, rd_ptr_in;
   logic                         pv_ff, pv_in;
   logic [ADDR_W-1:0]            pidx_ff, pidx_in;
   logic                         hit_ff, hit_in;
   logic [ADDR_W-1:0]            where_ff, where_in;
   logic [DATA_W-1:0]            acc_ff, acc_in;
   logic [alen_pkg::STAT_W-1:0]  status_ff, status_in;
   logic                         rsp_valid_ff, rsp_valid_in;
   logic [alen_pkg::RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;

   logic [DATA_W-1:0]            list_mem [alen_pkg::CAPACITY];
   logic [DATA_W-1:0]            rd_data_ff;
   logic                         mem_we, mem_re;
   logic [ADDR_W-1:0]            mem_wa, mem_ra;
   logic [DATA_W-1:0]            mem_wd;

   logic                         req_accept;
   logic [DATA_W-1:0]            req_value, req_nval;
   logic [alen_pkg::SLOT_W-1:0]  req_slot;
   logic [DATA_W-1:0]            cmp_b;
   alen_pkg::cmp_res_type        cmp_res;
   logic                         walk_end;
   logic [ADDR_W-1:0]            out_found;
   logic [DATA_W-1:0]            out_largest;

   assign req_tready = (state_ff == ST_IDLE);
   assign req_accept = req_tvalid && req_tready;
   assign req_value  = req_tdata[DATA_W-1:0];
   assign req_nval   = req_tdata[2*DATA_W-1:DATA_W];
   assign req_slot   = req_tdata[2*DATA_W+alen_pkg::SLOT_W-1:2*DATA_W];

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // The maximum scan compares against the running best; all others against the operand.
   assign cmp_b = (kind_ff == alen_pkg::KIND_MAX) ? acc_ff : value_ff;

   alen_cmp u_cmp (
      .a   (rd_data_ff),
      .b   (cmp_b),
      .res (cmp_res)
   );

   assign walk_end    = (rd_ptr_ff >= count_ff) && !pv_ff;
   assign out_found   = (kind_ff == alen_pkg::KIND_FIND && status_ff == alen_pkg::STAT_OK)
                        ? where_ff : '0;
   assign out_largest = (kind_ff == alen_pkg::KIND_MAX && status_ff == alen_pkg::STAT_OK)
                        ? acc_ff : '0;

   always_comb begin
      state_in     = state_ff;
      kind_in      = kind_ff;
      value_in     = value_ff;
      nval_in      = nval_ff;
      count_in     = count_ff;
      rd_ptr_in    = rd_ptr_ff;
      pv_in        = 1'b0;
      pidx_in      = pidx_ff;
      hit_in       = hit_ff;
      where_in     = where_ff;
      acc_in       = acc_ff;
      status_in    = status_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      mem_we       = 1'b0;
      mem_wa       = '0;
      mem_wd       = '0;
      mem_re       = 1'b0;
      mem_ra       = '0;

      // Read issue for both list walks: one word per cycle, data arriving in the next cycle.
      if ((state_ff == ST_WALK || state_ff == ST_SHIFT) && rd_ptr_ff < count_ff) begin
         mem_re    = 1'b1;
         mem_ra    = rd_ptr_ff[ADDR_W-1:0];
         rd_ptr_in = rd_ptr_ff + CNT_W'(1);
         pv_in     = 1'b1;
         pidx_in   = rd_ptr_ff[ADDR_W-1:0];
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               kind_in   = req_tuser;
               value_in  = req_value;
               nval_in   = req_nval;
               rd_ptr_in = '0;
               hit_in    = 1'b0;
               where_in  = '0;
               acc_in    = '0;
               status_in = alen_pkg::STAT_OK;
               state_in  = ST_FINISH;
               unique case (req_tuser)
                  alen_pkg::KIND_APPEND: begin
                     if (count_ff >= CNT_W'(alen_pkg::CAPACITY)) begin
                        status_in = alen_pkg::STAT_FULL;
                     end else begin
                        mem_we   = 1'b1;
                        mem_wa   = count_ff[ADDR_W-1:0];
                        mem_wd   = req_value;
                        count_in = count_ff + CNT_W'(1);
                     end
                  end
                  alen_pkg::KIND_WRITE: begin
                     if (CNT_W'(req_slot) < count_ff) begin
                        mem_we = 1'b1;
                        mem_wa = ADDR_W'(req_slot);
                        mem_wd = req_value;
                     end else begin
                        status_in = alen_pkg::STAT_RANGE;
                     end
                  end
                  alen_pkg::KIND_REPLACE, alen_pkg::KIND_DELETE,
                  alen_pkg::KIND_FIND, alen_pkg::KIND_MAX: begin
                     if (count_ff == '0) begin
                        status_in = (req_tuser == alen_pkg::KIND_MAX)
                                    ? alen_pkg::STAT_EMPTY : alen_pkg::STAT_NOT_FOUND;
                     end else begin
                        state_in = ST_WALK;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_WALK: begin
            if (walk_end) begin
               status_in = (hit_ff || kind_ff == alen_pkg::KIND_MAX)
                           ? alen_pkg::STAT_OK : alen_pkg::STAT_NOT_FOUND;
               state_in  = ST_FINISH;
            end else if (pv_ff) begin
               unique case (kind_ff)
                  alen_pkg::KIND_REPLACE: begin
                     if (cmp_res.eq) begin
                        mem_we = 1'b1;
                        mem_wa = pidx_ff;
                        mem_wd = nval_ff;
                        hit_in = 1'b1;
                     end
                  end
                  alen_pkg::KIND_FIND: begin
                     if (cmp_res.eq) begin
                        where_in = pidx_ff;
                        hit_in   = 1'b1;
                     end
                  end
                  alen_pkg::KIND_MAX: begin
                     if (!hit_ff || cmp_res.gt) begin
                        acc_in = rd_data_ff;
                        hit_in = 1'b1;
                     end
                  end
                  alen_pkg::KIND_DELETE: begin
                     // First match found: restart the walk just past it to move the tail.
                     if (cmp_res.eq) begin
                        rd_ptr_in = CNT_W'(pidx_ff) + CNT_W'(1);
                        pv_in     = 1'b0;
                        state_in  = ST_SHIFT;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_SHIFT: begin
            if (walk_end) begin
               count_in  = count_ff - CNT_W'(1);
               status_in = alen_pkg::STAT_OK;
               state_in  = ST_FINISH;
            end else if (pv_ff) begin
               mem_we = 1'b1;
               mem_wa = pidx_ff - ADDR_W'(1);
               mem_wd = rd_data_ff;
            end
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = alen_pkg::RSP_DATA_W'({count_ff, out_largest, out_found,
                                                     status_ff});
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         list_mem[mem_wa] <= mem_wd;
      end
      if (mem_re) begin
         rd_data_ff <= list_mem[mem_ra];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         pv_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         pv_ff        <= pv_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff     <= kind_in;
      value_ff    <= value_in;
      nval_ff     <= nval_in;
      rd_ptr_ff   <= rd_ptr_in;
      pidx_ff     <= pidx_in;
      hit_ff      <= hit_in;
      where_ff    <= where_in;
      acc_ff      <= acc_in;
      status_ff   <= status_in;
      rsp_data_ff <= rsp_data_in;
   end

   // The count can never pass the capacity.
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(alen_pkg::CAPACITY))
      else $error("list count exceeds capacity");

   // An accepted request always leaves the idle state.
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> state_ff != ST_IDLE)
      else $error("sequencer stayed idle after accepting a request");

   // The tail move never writes below the first slot.
   a_shift_index: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SHIFT) && pv_ff |-> pidx_ff != '0)
      else $error("tail move reads slot zero");

   // An empty report only comes with an empty list.
   a_empty_len: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[alen_pkg::STAT_W-1:0] == alen_pkg::STAT_EMPTY
      |-> rsp_tdata[alen_pkg::RSP_RAW_W-1:alen_pkg::RSP_RAW_W-CNT_W] == '0)
      else $error("empty status with nonzero length");

endmodule

// ===== dv/testbench.sv =====
// Self-checking testbench for array_list_engine_core: drives list requests, predicts results.
// Depends on alen_pkg and the array_list_engine_core RTL.
`timescale 1ns / 1ps

module testbench;

   localparam logic [alen_pkg::KIND_W-1:0] KIND_UNUSED_LO = 3'd6;
   localparam logic [alen_pkg::KIND_W-1:0] KIND_UNUSED_HI = 3'd7;
   localparam int HOLD_CYCLES    = 300;
   localparam int WATCHDOG_LIMIT = 20000;
   localparam int MAX_REPORTS    = 10;

   typedef logic signed [alen_pkg::DATA_W-1:0] word_type;

   typedef struct {
      logic [alen_pkg::KIND_W-1:0] kind;
      word_type                    value;
      word_type                    new_value;
      logic [alen_pkg::SLOT_W-1:0] slot;
   } list_op_type;

   // Same bit order as rsp_tdata, so the response casts straight onto it.
   typedef struct packed {
      logic [alen_pkg::CNT_W-1:0]  length;
      logic [alen_pkg::DATA_W-1:0] largest;
      logic [alen_pkg::SLOT_W-1:0] found_at;
      logic [alen_pkg::STAT_W-1:0] status;
   } list_result_type;

   logic                            clock = 1'b0;
   logic                            reset = 1'b1;
   logic                            req_tvalid = 1'b0;
   logic                            req_tready;
   logic [alen_pkg::REQ_DATA_W-1:0] req_tdata = '0;
   logic [alen_pkg::KIND_W-1:0]     req_tuser = '0;
   logic                            rsp_tvalid;
   logic                            rsp_tready = 1'b0;
   logic [alen_pkg::RSP_DATA_W-1:0] rsp_tdata;

   list_op_type     pending_ops[$];
   list_result_type expected_results[$];
   word_type        plan_list[$];   // list contents as the stimulus will leave them
   word_type        live_list[$];   // list contents after the last accepted request
   list_op_type     cur_op;

   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int hold_req_cnt  = 0;
   int hold_seen_cnt = 0;
   int hold_left     = 0;
   int error_count   = 0;
   int accepted_reqs = 0;
   int checked_rsps  = 0;
   int peak_length   = 0;
   int idle_cycles   = 0;

   array_list_engine_core u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Applies one list operation to a list and returns the response it yields.
   function automatic list_result_type apply_op(ref word_type words[$],
                                                input list_op_type op);
      list_result_type r;
      int              first;
      bit              hit;
      word_type        big;
      r = '0;
      hit = 1'b0;
      case (op.kind)
         alen_pkg::KIND_APPEND: begin
            if (words.size() >= alen_pkg::CAPACITY) r.status = alen_pkg::STAT_FULL;
            else words.push_back(op.value);
         end
         alen_pkg::KIND_REPLACE: begin
            foreach (words[i]) begin
               if (words[i] == op.value) begin
                  words[i] = op.new_value;
                  hit = 1'b1;
               end
            end
            if (!hit) r.status = alen_pkg::STAT_NOT_FOUND;
         end
         alen_pkg::KIND_DELETE: begin
            first = -1;
            foreach (words[i]) begin
               if (first < 0 && words[i] == op.value) first = i;
            end
            if (first < 0) r.status = alen_pkg::STAT_NOT_FOUND;
            else words.delete(first);
         end
         alen_pkg::KIND_FIND: begin
            foreach (words[i]) begin
               if (words[i] == op.value) begin
                  r.found_at = alen_pkg::SLOT_W'(i);
                  hit = 1'b1;
               end
            end
            if (!hit) r.status = alen_pkg::STAT_NOT_FOUND;
         end
         alen_pkg::KIND_WRITE: begin
            if (int'(op.slot) < words.size()) words[op.slot] = op.value;
            else r.status = alen_pkg::STAT_RANGE;
         end
         alen_pkg::KIND_MAX: begin
            if (words.size() == 0) begin
               r.status = alen_pkg::STAT_EMPTY;
            end else begin
               big = words[0];
               foreach (words[i]) begin
                  if (words[i] > big) big = words[i];
               end
               r.largest = big;
            end
         end
         default: ;
      endcase
      r.length = alen_pkg::CNT_W'(words.size());
      return r;
   endfunction

   function automatic list_op_type mk_op(logic [alen_pkg::KIND_W-1:0] kind, word_type value,
                                         word_type new_value,
                                         logic [alen_pkg::SLOT_W-1:0] slot);
      list_op_type op;
      op.kind = kind;
      op.value = value;
      op.new_value = new_value;
      op.slot = slot;
      return op;
   endfunction

   // Mostly values already in the list or from a few corner values, so that
   // searches hit and duplicates build up; the rest are fully random words.
   function automatic word_type pick_value();
      int sel;
      sel = $urandom_range(9);
      if (sel < 4 && plan_list.size() != 0)
         return plan_list[$urandom_range(plan_list.size() - 1)];
      if (sel < 7) begin
         case ($urandom_range(5))
            0: return 32'sd0;
            1: return 32'sd1;
            2: return -32'sd1;
            3: return 32'sd42;
            4: return 32'h7fff_ffff;
            default: return 32'h8000_0000;
         endcase
      end
      return word_type'($urandom);
   endfunction

   // Keeps the list short so that the walking operations stay quick.
   function automatic list_op_type random_op();
      list_op_type op;
      int n, sel, w_app, w_del;
      n = plan_list.size();
      op.value = pick_value();
      op.new_value = pick_value();
      if (n != 0 && $urandom_range(3) != 0)
         op.slot = alen_pkg::SLOT_W'($urandom_range(n - 1));
      else
         op.slot = alen_pkg::SLOT_W'($urandom_range(1023));
      w_app = (n < 6) ? 50 : (n > 40) ? 5 : 22;
      w_del = (n > 40) ? 35 : 14;
      sel = $urandom_range(99);
      if (sel < 3) op.kind = sel[0] ? KIND_UNUSED_HI : KIND_UNUSED_LO;
      else if (sel < 3 + w_app) op.kind = alen_pkg::KIND_APPEND;
      else if (sel < 3 + w_app + w_del) op.kind = alen_pkg::KIND_DELETE;
      else begin
         case (sel % 4)
            0: op.kind = alen_pkg::KIND_REPLACE;
            1: op.kind = alen_pkg::KIND_FIND;
            2: op.kind = alen_pkg::KIND_WRITE;
            default: op.kind = alen_pkg::KIND_MAX;
         endcase
      end
      return op;
   endfunction

   task automatic plan_op(input list_op_type op);
      void'(apply_op(plan_list, op));
      pending_ops.push_back(op);
   endtask

   task automatic plan_random(input int n_items);
      repeat (n_items) plan_op(random_op());
   endtask

   task automatic wait_drained();
      while (pending_ops.size() != 0 || expected_results.size() != 0 || req_tvalid)
         @(negedge clock);
   endtask

   task automatic flag_error(input string msg);
      error_count++;
      if (error_count <= MAX_REPORTS) $display("ERROR: %s", msg);
   endtask

   // Request driver: predicts each accepted request, then offers the next one.
   always @(posedge clock) begin : req_driver
      bit holding;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         holding = req_tvalid && !req_tready;
         if (req_tvalid && req_tready) begin
            expected_results.push_back(apply_op(live_list, cur_op));
            accepted_reqs++;
         end
         if (!holding) begin
            if (pending_ops.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               cur_op = pending_ops.pop_front();
               req_tdata <= {{(alen_pkg::REQ_DATA_W - alen_pkg::REQ_RAW_W){1'b0}},
                             cur_op.slot, cur_op.new_value, cur_op.value};
               req_tuser <= cur_op.kind;
               req_tvalid <= 1'b1;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // Response sink with random stalls and an occasional long hold-off.
   always @(posedge clock) begin : rsp_sink
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else if (hold_seen_cnt != hold_req_cnt) begin
         hold_seen_cnt = hold_req_cnt;
         hold_left = HOLD_CYCLES;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   always @(posedge clock) begin : rsp_check
      list_result_type got, want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = list_result_type'(rsp_tdata[alen_pkg::RSP_RAW_W-1:0]);
         checked_rsps++;
         if (int'(got.length) > peak_length) peak_length = got.length;
         if (expected_results.size() == 0) begin
            flag_error($sformatf({"response with none expected: status %0d found_at %0d ",
                                  "largest %0d length %0d"},
                                 got.status, got.found_at, $signed(got.largest),
                                 got.length));
         end else begin
            want = expected_results.pop_front();
            if (got.status !== want.status || got.found_at !== want.found_at ||
                got.largest !== want.largest || got.length !== want.length)
               flag_error($sformatf({"response %0d: expected status %0d found_at %0d ",
                                     "largest %0d length %0d, got status %0d ",
                                     "found_at %0d largest %0d length %0d"},
                                    checked_rsps, want.status, want.found_at,
                                    $signed(want.largest), want.length, got.status,
                                    got.found_at, $signed(got.largest), got.length));
         end
      end
   end

   always @(posedge clock) begin : watchdog
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles = 0;
      end else begin
         idle_cycles++;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Timeout: no request or response moved for %0d cycles", WATCHDOG_LIMIT);
            $display("DONE: errors detected");
            $finish;
         end
      end
   end

   initial begin : stimulus
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      send_idle_pct = 16;
      recv_idle_pct = 52;
      // Empty list: every search fails, max reports empty, no slot is valid.
      plan_op(mk_op(alen_pkg::KIND_MAX, 0, 0, 10'd0));
      plan_op(mk_op(alen_pkg::KIND_FIND, 0, 0, 10'd0));
      plan_op(mk_op(alen_pkg::KIND_DELETE, 0, 0, 10'd0));
      plan_op(mk_op(alen_pkg::KIND_REPLACE, 0, 1, 10'd0));
      plan_op(mk_op(alen_pkg::KIND_WRITE, 5, 0, 10'd0));
      plan_op(mk_op(KIND_UNUSED_LO, -1, -1, 10'h3ff));
      plan_op(mk_op(KIND_UNUSED_HI, 32'h8000_0000, 32'h7fff_ffff, 10'h155));
      plan_op(mk_op(alen_pkg::KIND_APPEND, 32'h7fff_ffff, 0, 10'd0));
      plan_op(mk_op(alen_pkg::KIND_APPEND, 32'h8000_0000, 0, 10'd0));
      plan_op(mk_op(alen_pkg::KIND_APPEND, 0, 0, 10'd0));
      plan_op(mk_op(alen_pkg::KIND_APPEND, 32'h7fff_ffff, 0, 10'd0));
      plan_op(mk_op(alen_pkg::KIND_APPEND, -1, 0, 10'd0));
      // Duplicates: find reports the last one, replace hits all of them,
      // delete removes only the first.
      plan_op(mk_op(alen_pkg::KIND_FIND, 32'h7fff_ffff, 0, 10'd0));
      plan_op(mk_op(alen_pkg::KIND_MAX, 0, 0, 10'd0));
      plan_op(mk_op(alen_pkg::KIND_REPLACE, 32'h7fff_ffff, 32'h8000_0000, 10'd0));
      plan_op(mk_op(alen_pkg::KIND_FIND, 32'h8000_0000, 0, 10'd0));
      plan_op(mk_op(alen_pkg::KIND_DELETE, 32'h8000_0000, 0, 10'd0));
      plan_op(mk_op(alen_pkg::KIND_MAX, 0, 0, 10'd0));
      plan_op(mk_op(alen_pkg::KIND_WRITE, 32'h7fff_ffff, 0, 10'd3));
      plan_op(mk_op(alen_pkg::KIND_WRITE, 7, 0, 10'd4));
      plan_op(mk_op(alen_pkg::KIND_WRITE, 7, 0, 10'h3ff));
      plan_op(mk_op(alen_pkg::KIND_MAX, 0, 0, 10'd0));
      plan_op(mk_op(alen_pkg::KIND_DELETE, 42, 0, 10'd0));
      plan_op(mk_op(alen_pkg::KIND_REPLACE, -1, 32'h7fff_ffff, 10'd0));
      plan_random(186);
      wait_drained();

      send_idle_pct = 52;
      recv_idle_pct = 16;
      plan_random(186);
      // Long response stall while requests keep coming: the block must back up.
      hold_req_cnt++;
      wait_drained();

      send_idle_pct = 0;
      recv_idle_pct = 0;
      plan_random(184);
      wait_drained();

      repeat (100) @(negedge clock);
      if (expected_results.size() != 0)
         flag_error($sformatf("%0d responses never arrived", expected_results.size()));
      $display("Summary: %0d requests accepted, %0d responses checked, list length up to %0d.",
               accepted_reqs, checked_rsps, peak_length);
      $display("Covered empty and partly filled lists, duplicates and bad slots under stalls.");
      if (error_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
